// ===== hw/rtl/kctrs_pkg.sv =====
// shared widths, codes and chain token types for the keyed count table
// depends on nothing; imported by kctrs_cell and the top level
`default_nettype none

package kctrs_pkg;

	localparam int TABLE_ENTRIES_DEF = 16;

	localparam int KEY_W = 8;
	localparam int AMT_W = 16;
	localparam int CNT_W = 24;
	localparam int SUM_W = 28;
	localparam int ST_W  = 2;

	localparam logic [CNT_W-1:0] COUNT_MAX = '1;
	localparam logic [SUM_W-1:0] SUM_MAX   = '1;

	localparam logic FUNC_ADD   = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	localparam logic [ST_W-1:0] ST_UPDATED  = 2'd0;
	localparam logic [ST_W-1:0] ST_INSERTED = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
	localparam logic [ST_W-1:0] ST_QUERY    = 2'd3;

	// command travelling along the chain, one cell per cycle
	typedef struct packed {
		logic             func;
		logic [KEY_W-1:0] key;
		logic [AMT_W-1:0] amount;
		logic [KEY_W-1:0] range_low;
		logic [KEY_W-1:0] range_high;
		logic             hit;
		logic             inserted;
		logic [SUM_W-1:0] sum;
	} token_t;

	// per-cell occupancy from the fill counter
	typedef struct packed {
		logic used;
		logic head;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/kctrs_cell.sv =====
// one table slot: key and count storage plus the token stage behind it
// depends on kctrs_pkg
`default_nettype none

module kctrs_cell (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire kctrs_pkg::cell_ctl_t ctl,
	input  wire                 in_vld,
	input  wire kctrs_pkg::token_t in_tok,
	output logic                out_vld,
	output kctrs_pkg::token_t   out_tok
);
	import kctrs_pkg::*;

	logic [KEY_W-1:0] key_q;
	logic [CNT_W-1:0] count_q;

	token_t           tok_nxt;
	logic             key_wr;
	logic             cnt_wr;
	logic [CNT_W-1:0] cnt_nxt;
	logic [CNT_W:0]   cnt_wide;
	logic [SUM_W:0]   sum_wide;
	logic             in_range;

	assign cnt_wide = {1'b0, count_q} + {{(CNT_W+1-AMT_W){1'b0}}, in_tok.amount};
	assign sum_wide = {1'b0, in_tok.sum} + {{(SUM_W+1-CNT_W){1'b0}}, count_q};
	assign in_range = (key_q >= in_tok.range_low) && (key_q <= in_tok.range_high);

	always_comb begin
		tok_nxt = in_tok;
		key_wr  = 1'b0;
		cnt_wr  = 1'b0;
		cnt_nxt = count_q;
		if (in_vld) begin
			if (in_tok.func == FUNC_QUERY) begin
				if (ctl.used && in_range) begin
					tok_nxt.sum = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
				end
			end else if (ctl.used) begin
				if (!in_tok.hit && key_q == in_tok.key) begin
					tok_nxt.hit = 1'b1;
					cnt_wr      = 1'b1;
					cnt_nxt     = cnt_wide[CNT_W] ? COUNT_MAX : cnt_wide[CNT_W-1:0];
				end
			end else if (ctl.head && !in_tok.hit) begin
				// first free slot takes a key that missed every used slot
				tok_nxt.inserted = 1'b1;
				key_wr           = 1'b1;
				cnt_wr           = 1'b1;
				cnt_nxt          = {{(CNT_W-AMT_W){1'b0}}, in_tok.amount};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (key_wr) begin
			key_q <= in_tok.key;
		end
		if (cnt_wr) begin
			count_q <= cnt_nxt;
		end
		out_tok <= tok_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else begin
			out_vld <= in_vld;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/keyed_count_table_range_sum_core.sv =====
// keyed count table with inclusive range sum, built as a row of slot cells
// depends on kctrs_pkg and kctrs_cell
`default_nettype none

// usage
// - command channel: a beat is taken at the rising edge where start is high
//   and busy is low; func picks add (key, amount) or range query
//   (range_low, range_high)
// - result channel: done is high for exactly one cycle with status and
//   total_cases; the receiver cannot stall, so results are never held
// - one command at a time: busy rises after the accepting edge and falls
//   once the command has walked every cell
// - the command passes one cell per cycle from the launch register through
//   every cell, and done is registered from the last cell; a new command
//   may be taken at the edge that ends the cycle where done is shown
// - adds match a used slot and add saturating at 24 bits, otherwise fill
//   the first free slot or report full; queries sum matching counts,
//   saturating at 28 bits
// - reset clears the fill count, busy and done; slot contents are not
//   cleared, as only slots below the fill count are ever looked at

module keyed_count_table_range_sum_core #(
	parameter int TABLE_ENTRIES = kctrs_pkg::TABLE_ENTRIES_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             start,
	output logic                            busy,
	input  wire                             func,
	input  wire  [kctrs_pkg::KEY_W-1:0]     key,
	input  wire  [kctrs_pkg::AMT_W-1:0]     amount,
	input  wire  [kctrs_pkg::KEY_W-1:0]     range_low,
	input  wire  [kctrs_pkg::KEY_W-1:0]     range_high,
	output logic                            done,
	output logic [kctrs_pkg::ST_W-1:0]      status,
	output logic [kctrs_pkg::SUM_W-1:0]     total_cases
);
	import kctrs_pkg::*;

	localparam int USED_W = $clog2(TABLE_ENTRIES + 1);

	// fill count: slots below it hold keys, the slot at it is the next free
	logic [USED_W-1:0] entries_used_q;
	logic              busy_q;
	logic              done_q;
	logic [ST_W-1:0]   status_q;
	logic [SUM_W-1:0]  total_q;

	logic              accept;
	logic              finish;

	// token chain: stage 0 is the launch register, stage i+1 leaves cell i
	logic      vld [TABLE_ENTRIES+1];
	token_t    tok [TABLE_ENTRIES+1];
	cell_ctl_t ctl [TABLE_ENTRIES];

	logic      launch_vld_q;
	token_t    launch_tok_q;

	assign accept = start && !busy_q;
	assign finish = vld[TABLE_ENTRIES];

	// launch register: command beat enters the chain with a clean sum
	always_ff @(posedge clk) begin
		if (accept) begin
			launch_tok_q.func       <= func;
			launch_tok_q.key        <= key;
			launch_tok_q.amount     <= amount;
			launch_tok_q.range_low  <= range_low;
			launch_tok_q.range_high <= range_high;
			launch_tok_q.hit        <= 1'b0;
			launch_tok_q.inserted   <= 1'b0;
			launch_tok_q.sum        <= '0;
		end
	end

	assign vld[0] = launch_vld_q;
	assign tok[0] = launch_tok_q;

	genvar gi;
	generate
		for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
			assign ctl[gi].used = (USED_W'(gi) < entries_used_q);
			assign ctl[gi].head = (USED_W'(gi) == entries_used_q);

			kctrs_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctl     (ctl[gi]),
				.in_vld  (vld[gi]),
				.in_tok  (tok[gi]),
				.out_vld (vld[gi+1]),
				.out_tok (tok[gi+1])
			);
		end
	endgenerate

	// control: busy spans the walk, fill count moves when an insert lands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q         <= 1'b0;
			launch_vld_q   <= 1'b0;
			done_q         <= 1'b0;
			entries_used_q <= '0;
		end else begin
			launch_vld_q <= accept;
			done_q       <= finish;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
			end
			if (finish && tok[TABLE_ENTRIES].func == FUNC_ADD &&
			    tok[TABLE_ENTRIES].inserted) begin
				entries_used_q <= entries_used_q + USED_W'(1);
			end
		end
	end

	// result register, shown for the single cycle that done is high
	always_ff @(posedge clk) begin
		if (finish) begin
			priority if (tok[TABLE_ENTRIES].func == FUNC_QUERY) begin
				status_q <= ST_QUERY;
				total_q  <= tok[TABLE_ENTRIES].sum;
			end else if (tok[TABLE_ENTRIES].hit) begin
				status_q <= ST_UPDATED;
				total_q  <= '0;
			end else if (tok[TABLE_ENTRIES].inserted) begin
				status_q <= ST_INSERTED;
				total_q  <= '0;
			end else begin
				status_q <= ST_FULL;
				total_q  <= '0;
			end
		end
	end

	assign busy        = busy_q;
	assign done        = done_q;
	assign status      = status_q;
	assign total_cases = total_q;

	// checks

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while a command is still walking");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted command did not raise busy");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entries_used_q <= USED_W'(TABLE_ENTRIES))
		else $error("fill count beyond table size");

	a_insert_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_INSERTED) |-> (entries_used_q != $past(entries_used_q)))
		else $error("insert reported without fill count moving");

	a_add_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_QUERY) |-> (total_cases == '0))
		else $error("add result with nonzero total");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// self-checking bench for keyed_count_table_range_sum_core: directed and random commands
// depends on kctrs_pkg and the core; a table tracker class predicts each result beat

// mirrors the slot table and holds the result beats still owed by the core
class table_tracker;
	typedef struct packed {
		logic [kctrs_pkg::ST_W-1:0]  status;
		logic [kctrs_pkg::SUM_W-1:0] total;
	} outcome_t;

	localparam int SLOTS = kctrs_pkg::TABLE_ENTRIES_DEF;

	logic [kctrs_pkg::KEY_W-1:0] slot_key   [SLOTS];
	logic [kctrs_pkg::CNT_W-1:0] slot_count [SLOTS];
	int                          slots_used;
	outcome_t                    owed_results [$];
	int                          mismatches;

	function new();
		slots_used = 0;
		mismatches = 0;
	endfunction

	// apply one accepted command beat and queue the result it must produce
	function void note_command(logic f, logic [kctrs_pkg::KEY_W-1:0] k,
			logic [kctrs_pkg::AMT_W-1:0] a, logic [kctrs_pkg::KEY_W-1:0] lo,
			logic [kctrs_pkg::KEY_W-1:0] hi);
		outcome_t                  res;
		logic [kctrs_pkg::CNT_W:0] grown;
		logic [31:0]               sum;
		int                        hit;
		int                        i;
		res = '0;
		hit = -1;
		sum = 0;
		if (f == kctrs_pkg::FUNC_QUERY) begin
			for (i = 0; i < slots_used; i++)
				if (slot_key[i] >= lo && slot_key[i] <= hi)
					sum += 32'(slot_count[i]);
			res.status = kctrs_pkg::ST_QUERY;
			res.total  = (sum > kctrs_pkg::SUM_MAX) ? kctrs_pkg::SUM_MAX
				: sum[kctrs_pkg::SUM_W-1:0];
		end else begin
			for (i = 0; i < slots_used; i++)
				if (hit < 0 && slot_key[i] == k)
					hit = i;
			if (hit >= 0) begin
				grown = {1'b0, slot_count[hit]} + (kctrs_pkg::CNT_W+1)'(a);
				slot_count[hit] = grown[kctrs_pkg::CNT_W] ? kctrs_pkg::COUNT_MAX
					: grown[kctrs_pkg::CNT_W-1:0];
				res.status = kctrs_pkg::ST_UPDATED;
			end else if (slots_used >= SLOTS) begin
				res.status = kctrs_pkg::ST_FULL;
			end else begin
				slot_key[slots_used]   = k;
				slot_count[slots_used] = kctrs_pkg::CNT_W'(a);
				slots_used++;
				res.status = kctrs_pkg::ST_INSERTED;
			end
		end
		owed_results.push_back(res);
	endfunction

	function void check_result(logic [kctrs_pkg::ST_W-1:0] st,
			logic [kctrs_pkg::SUM_W-1:0] tot);
		outcome_t want;
		if (owed_results.size() == 0) begin
			$display("%0t: unexpected result, status %0d total_cases %0d", $time, st, tot);
			mismatches++;
		end else begin
			want = owed_results.pop_front();
			if (st !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status, st);
				mismatches++;
			end
			if (tot !== want.total) begin
				$display("%0t: total_cases expected %0d actual %0d", $time, want.total, tot);
				mismatches++;
			end
		end
	endfunction

	function int pending();
		return owed_results.size();
	endfunction

	// a key already in the table (random while it is empty), so adds hit and query bounds land on real keys
	function logic [kctrs_pkg::KEY_W-1:0] stored_key();
		if (slots_used == 0)
			return kctrs_pkg::KEY_W'($urandom);
		return slot_key[$urandom_range(slots_used - 1)];
	endfunction
endclass

module tb;
	import kctrs_pkg::*;

	// random commands after the directed opening
	localparam int RANDOM_ITEMS = 1650;
	// early stretch that piles big amounts onto one key until it saturates
	localparam int HAMMER_ITEMS = 400;
	localparam int HAMMER_KEY   = 255;

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               start      = 1'b0;
	logic               func       = FUNC_ADD;
	logic [KEY_W-1:0]   key        = '0;
	logic [AMT_W-1:0]   amount     = '0;
	logic [KEY_W-1:0]   range_low  = '0;
	logic [KEY_W-1:0]   range_high = '0;
	logic               busy;
	logic               done;
	logic [ST_W-1:0]    status;
	logic [SUM_W-1:0]   total_cases;

	table_tracker tracker;

	always #4 clk = ~clk;

	keyed_count_table_range_sum_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.key         (key),
		.amount      (amount),
		.range_low   (range_low),
		.range_high  (range_high),
		.done        (done),
		.status      (status),
		.total_cases (total_cases)
	);

	// present one command and hold it until the core takes the beat;
	// start is left high so back-to-back beats need no extra cycle
	task automatic send_item(input logic f, input logic [KEY_W-1:0] k,
			input logic [AMT_W-1:0] a, input logic [KEY_W-1:0] lo,
			input logic [KEY_W-1:0] hi);
		start      <= 1'b1;
		func       <= f;
		key        <= k;
		amount     <= a;
		range_low  <= lo;
		range_high <= hi;
		// values read here are the ones from before the edge
		do @(posedge clk); while (busy);
		tracker.note_command(f, k, a, lo, hi);
	endtask

	// sender gap of up to a bit more than one pass of the core, so the
	// next start rises at any point of the walk or well after it
	task automatic sender_pause(input int pct);
		if ($urandom_range(99) < pct) begin
			start <= 1'b0;
			repeat ($urandom_range(24, 1)) @(posedge clk);
		end
	endtask

	task automatic send_random_item(input bit hammer);
		logic [KEY_W-1:0] k;
		logic [KEY_W-1:0] lo;
		logic [KEY_W-1:0] hi;
		logic [AMT_W-1:0] a;
		int               pick;
		k    = KEY_W'($urandom);
		a    = AMT_W'($urandom);
		lo   = KEY_W'($urandom);
		hi   = KEY_W'($urandom);
		pick = $urandom_range(99);
		if (hammer && pick < 75)
			send_item(FUNC_ADD, KEY_W'(HAMMER_KEY), AMT_W'($urandom_range(65535, 60000)),
				lo, hi);
		else if (pick < 55)
			send_item(FUNC_ADD, tracker.stored_key(), a, lo, hi);
		else if (pick < 65)
			// mostly misses once the table is full
			send_item(FUNC_ADD, k, a, lo, hi);
		else if (pick < 85)
			// bounds on stored keys, in either order
			send_item(FUNC_QUERY, k, a, tracker.stored_key(), tracker.stored_key());
		else
			send_item(FUNC_QUERY, k, a, lo, hi);
	endtask

	// every result beat is shown for one cycle only, so check it at that edge
	always @(posedge clk)
		if (arst_n && done)
			tracker.check_result(status, total_cases);

	initial begin
		int i;
		int waited;
		int idle_pct;
		tracker = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed opening
		// query on an empty table
		send_item(FUNC_QUERY, 8'h00, 16'h0000, 8'h00, 8'hFF);
		// lowest key with zero amount, then a hit on it
		send_item(FUNC_ADD, 8'h00, 16'h0000, 8'h00, 8'h00);
		send_item(FUNC_ADD, 8'h00, 16'hFFFF, 8'h00, 8'h00);
		send_item(FUNC_ADD, 8'hFF, 16'hFFFF, 8'h00, 8'h00);
		// fill the remaining slots with single-bit and single-hole keys
		for (i = 0; i < 14; i++)
			send_item(FUNC_ADD, (i < 8) ? KEY_W'(1 << i) : 8'hFF ^ KEY_W'(1 << (i - 8)),
				AMT_W'($urandom), 8'h00, 8'h00);
		// miss on a full table is dropped
		send_item(FUNC_ADD, 8'h03, 16'h1234, 8'h00, 8'h00);
		send_item(FUNC_QUERY, 8'h00, 16'h0000, 8'h00, 8'hFF);
		// reversed bounds match nothing, though key 128 lies between them
		send_item(FUNC_QUERY, 8'h00, 16'h0000, 8'd200, 8'd100);
		// single-key ranges at both ends
		send_item(FUNC_QUERY, 8'h00, 16'h0000, 8'hFF, 8'hFF);
		send_item(FUNC_QUERY, 8'h00, 16'h0000, 8'h00, 8'h00);
		// unused fields carry junk and must be ignored
		send_item(FUNC_ADD, 8'd128, 16'hA5A5, 8'hFF, 8'h5A);
		send_item(FUNC_QUERY, 8'hC3, 16'hFFFF, 8'd1, 8'd64);

		// random part, with three levels of sender idling
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			idle_pct = (i < RANDOM_ITEMS / 3) ? 25 : (i < 2 * RANDOM_ITEMS / 3) ? 48 : 0;
			sender_pause(idle_pct);
			send_random_item(i < HAMMER_ITEMS);
		end
		start <= 1'b0;

		// drain, then give any stray beat a full pass to show up
		waited = 0;
		while (tracker.pending() != 0 && waited < 200) begin
			@(posedge clk);
			waited++;
		end
		repeat (TABLE_ENTRIES_DEF + 4) @(posedge clk);

		if (tracker.pending() != 0)
			$display("%0t: %0d expected results never arrived", $time, tracker.pending());
		if (tracker.mismatches == 0 && tracker.pending() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// watchdog, several times the slowest legal run
	initial begin
		#3_000_000;
		$display("FAILED: results differ");
		$finish;
	end
endmodule
